[rtl/core/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine: opcodes, status
// codes, the cell row command and the sequencer states.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Request opcodes (code 7 is unused and handled by default arms)
    typedef enum logic [2:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ_ALL  = 3'd6
    } opcode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // What every cell of the row does when clocked
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_ROTATE = 2'd3
    } cell_mode_t;

    // Command broadcast to the cell row
    typedef struct packed {
        cell_mode_t         mode;
        logic signed [31:0] value;
    } cell_ctl_t;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // A read-out run reports at most this many entries
    localparam int READ_LIMIT = 16;

endpackage

[rtl/core/ple_req_if.sv]
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel of the positional list engine: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface ple_req_if;

    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [4:0]         position;

    modport source
    (
        output valid,
        output opcode,
        output value,
        output position,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  opcode,
        input  value,
        input  position,
        output ready
    );

endinterface

[rtl/core/ple_rsp_if.sv]
// ----------------------------------------------------------------------------
// ple_rsp_if
// Result channel of the positional list engine: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface ple_rsp_if;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [3:0]         element_index;
    logic [4:0]         count_after;
    logic               last;

    modport source
    (
        output valid,
        output status,
        output element,
        output element_index,
        output count_after,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  status,
        input  element,
        input  element_index,
        input  count_after,
        input  last,
        output ready
    );

endinterface

[rtl/core/positional_list_engine_core.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values kept in a shifting row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (opcode, value, position); rsp returns results
//   (status, element, element_index, count_after, last). A transaction moves
//   when valid and ready are both high.
//   Inserts and deletes shift the whole cell row in the cycle that accepts
//   the request; the single result appears on rsp in the next cycle. A new
//   request is taken every cycle while rsp keeps up.
//   read_all rotates the row one cell per cycle while rsp keeps up, front
//   entry out of cell 0, and restores the original order at its end.
//   Results for the first 16 entries are sent, the last one with last set;
//   no request is taken during the run.
//   An empty list, a full list or a bad position gives one result with a
//   status code and leaves the list untouched.
//   When rsp stalls, the result stays in the output register and the block
//   holds req ready low (and pauses a read run) until it is taken.
//   Reset empties the list and drops any pending result; cell contents are
//   not cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ple_req_if.sink    req,
    ple_rsp_if.source  rsp
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW + 1 > 6) ? CW + 1 : 6;

    // Control state
    ple_pkg::state_t       state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IDXW-1:0]       rd_reg, rd_next;
    logic                  out_valid_reg, out_valid_next;

    // Output payload
    logic [1:0]            status_reg, status_next;
    logic signed [31:0]    element_reg, element_next;
    logic [3:0]            index_reg, index_next;
    logic [4:0]            cnt_out_reg, cnt_out_next;
    logic                  last_reg, last_next;

    // Cell row signals
    ple_pkg::cell_ctl_t    ctl;
    logic [IDXW-1:0]       k;
    logic [IDXW-1:0]       tail;
    logic signed [31:0]    cell_data [CAPACITY];
    logic signed [31:0]    cell_tap  [CAPACITY];
    logic signed [31:0]    removed;

    // Helpers
    logic                  out_free;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       rd_ext;
    logic [CMPW-1:0]       n_m1;
    logic                  rd_emit;
    logic                  rd_step;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ple_pkg::S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign cnt_ext = CMPW'(count_reg);
    assign pos_ext = CMPW'(req.position);
    assign rd_ext  = CMPW'(rd_reg);
    assign tail    = IDXW'(count_reg - CW'(1));

    // Last reported slot of a read run: min(count, limit) - 1
    assign n_m1 = (cnt_ext < CMPW'(ple_pkg::READ_LIMIT))
                  ? cnt_ext - CMPW'(1)
                  : CMPW'(ple_pkg::READ_LIMIT - 1);

    // Report while inside the limit; beyond it rotate without results
    assign rd_emit = (rd_ext < CMPW'(ple_pkg::READ_LIMIT));
    assign rd_step = (state_reg == ple_pkg::S_READ) && (!rd_emit || out_free);

    // Cell row
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic signed [31:0] left_d;
        logic signed [31:0] right_d;

        if (gi == 0)
        begin : g_first
            assign left_d = 32'sd0;
        end
        else
        begin : g_mid
            assign left_d = cell_data[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_end
            assign right_d = cell_data[gi];
        end
        else
        begin : g_inner
            assign right_d = cell_data[gi+1];
        end

        ple_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (gi)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .k          (k),
            .tail       (tail),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[gi]),
            .tap        (cell_tap[gi])
        );
    end

    // Collect the addressed entry from the cell taps
    always_comb
    begin
        removed = 32'sd0;
        for (int i = 0; i < CAPACITY; i++)
            removed = removed | cell_tap[i];
    end

    // Decode requests and sequence read runs
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        element_next   = element_reg;
        index_next     = index_reg;
        cnt_out_next   = cnt_out_reg;
        last_next      = last_reg;
        ctl.mode       = ple_pkg::MODE_HOLD;
        ctl.value      = req.value;
        k              = '0;

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ple_pkg::ST_OK;
            element_next   = 32'sd0;
            index_next     = 4'd0;
            last_next      = 1'b1;
            case (ple_pkg::opcode_t'(req.opcode))
                ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST, ple_pkg::OP_INS_AT:
                begin
                    if (full)
                        status_next = ple_pkg::ST_FULL;
                    else if (req.opcode == ple_pkg::OP_INS_AT &&
                             (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)))
                        status_next = ple_pkg::ST_RANGE;
                    else
                    begin
                        ctl.mode   = ple_pkg::MODE_INSERT;
                        count_next = count_reg + CW'(1);
                        if (req.opcode == ple_pkg::OP_INS_FIRST)
                            k = '0;
                        else if (req.opcode == ple_pkg::OP_INS_LAST)
                            k = IDXW'(count_reg);
                        else
                            k = IDXW'(req.position - 5'd1);
                    end
                end
                ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST, ple_pkg::OP_DEL_AT:
                begin
                    if (empty)
                        status_next = ple_pkg::ST_EMPTY;
                    else if (req.opcode == ple_pkg::OP_DEL_AT &&
                             (pos_ext == '0 || pos_ext > cnt_ext))
                        status_next = ple_pkg::ST_RANGE;
                    else
                    begin
                        ctl.mode   = ple_pkg::MODE_DELETE;
                        count_next = count_reg - CW'(1);
                        if (req.opcode == ple_pkg::OP_DEL_FIRST)
                            k = '0;
                        else if (req.opcode == ple_pkg::OP_DEL_LAST)
                            k = tail;
                        else
                            k = IDXW'(req.position - 5'd1);
                        element_next = removed;
                    end
                end
                ple_pkg::OP_READ_ALL:
                begin
                    if (empty)
                        status_next = ple_pkg::ST_EMPTY;
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ple_pkg::S_READ;
                        rd_next        = '0;
                    end
                end
                default:
                begin
                    status_next = ple_pkg::ST_OK;
                end
            endcase
            cnt_out_next = 5'(count_next);
        end
        else if (rd_step)
        begin
            // Rotate the row: cell 0 goes out and wraps to the tail
            ctl.mode = ple_pkg::MODE_ROTATE;
            if (rd_emit)
            begin
                out_valid_next = 1'b1;
                status_next    = ple_pkg::ST_OK;
                element_next   = cell_data[0];
                index_next     = rd_ext[3:0];
                cnt_out_next   = 5'(count_reg);
                last_next      = (rd_ext == n_m1);
            end
            if (rd_reg == tail)
            begin
                state_next = ple_pkg::S_IDLE;
                rd_next    = '0;
            end
            else
                rd_next = rd_reg + IDXW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::S_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        index_reg   <= index_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.element       = element_reg;
    assign rsp.element_index = index_reg;
    assign rsp.count_after   = cnt_out_reg;
    assign rsp.last          = last_reg;

endmodule

[rtl/core/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell
// One storage cell of the list row. Holds one entry and, on command, takes
// the new value, its left neighbor, its right neighbor or the row head.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0
) (
    input  logic                            clk,
    input  ple_pkg::cell_ctl_t              ctl,
    input  logic [$clog2(CAPACITY)-1:0]     k,
    input  logic [$clog2(CAPACITY)-1:0]     tail,
    input  logic signed [31:0]              left_data,
    input  logic signed [31:0]              right_data,
    input  logic signed [31:0]              head_data,
    output logic signed [31:0]              data,
    output logic signed [31:0]              tap
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    // Select the next content of this cell
    always_comb
    begin
        data_next = data_reg;
        case (ctl.mode)
            ple_pkg::MODE_INSERT:
            begin
                if (MY_IDX == k)
                    data_next = ctl.value;
                else if (MY_IDX > k)
                    data_next = left_data;
            end
            ple_pkg::MODE_DELETE:
            begin
                if (MY_IDX >= k)
                    data_next = right_data;
            end
            ple_pkg::MODE_ROTATE:
            begin
                if (MY_IDX == tail)
                    data_next = head_data;
                else if (MY_IDX < tail)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // Offer the entry on the removal tap when this cell is addressed
    assign tap = (MY_IDX == k) ? data_reg : 32'sd0;

endmodule

[rtl/core/ple_checker.sv]
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker #(
    parameter int CAPACITY = 16
) (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [2:0] req_opcode,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [4:0] rsp_count_after,
    input logic       rsp_last
);

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // A full report comes only with the list at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ple_pkg::ST_FULL |-> rsp_count_after == CAP_LOW)
        else $error("full status with list below capacity");

    // An empty report comes only with no entries
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ple_pkg::ST_EMPTY |-> rsp_count_after == 5'd0)
        else $error("empty status with entries present");

    // Only a successful read run has results that are not last
    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_status == ple_pkg::ST_OK)
        else $error("error status inside a read run");

    // A request other than read_all answers in the next cycle
    a_single_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_opcode != ple_pkg::OP_READ_ALL |=> rsp_valid)
        else $error("missing result after request");

endmodule

bind positional_list_engine_core ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_opcode      (req.opcode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_count_after (rsp.count_after),
    .rsp_last        (rsp.last)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. Requests are queued up
// front and driven on req with random gaps; results are taken from rsp with
// random stalls, plus one long hold-off that backs the block up. Every
// accepted request runs through a list mirror that predicts the result
// transactions, which are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIST_CAPACITY = 16;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 300;

    typedef struct {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [4:0]         position;
    } list_request_t;

    typedef struct {
        ple_pkg::status_t   status;
        logic signed [31:0] element;
        logic [3:0]         element_index;
        logic [4:0]         count_after;
        logic               last;
    } list_result_t;

    logic clk;
    logic rst_n;

    ple_req_if req_ch();
    ple_rsp_if rsp_ch();

    positional_list_engine_core #(
        .CAPACITY (LIST_CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_request_t      request_backlog[$];
    list_result_t       pending_results[$];
    logic signed [31:0] list_mirror[$];

    int  planned_count;
    int  accepted_requests;
    int  error_count;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_results;
    bit  req_fired;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Expected results
    // ------------------------------------------------------------------
    function automatic void push_outcome(ple_pkg::status_t status,
                                         logic signed [31:0] element,
                                         logic [3:0] element_index, logic last);
        list_result_t res;
        res.status        = status;
        res.element       = element;
        res.element_index = element_index;
        res.count_after   = 5'(list_mirror.size());
        res.last          = last;
        pending_results.push_back(res);
    endfunction

    // Apply one request to the list mirror and queue what it returns
    function automatic void predict_request(list_request_t r);
        int                 n;
        int                 at;
        logic signed [31:0] removed;
        case (r.opcode)
            ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST, ple_pkg::OP_INS_AT:
            begin
                // full check wins over the position check
                if (list_mirror.size() >= LIST_CAPACITY)
                    push_outcome(ple_pkg::ST_FULL, 0, 0, 1'b1);
                else if (r.opcode == ple_pkg::OP_INS_AT &&
                         (r.position < 1 || r.position > list_mirror.size() + 1))
                    push_outcome(ple_pkg::ST_RANGE, 0, 0, 1'b1);
                else
                begin
                    if (r.opcode == ple_pkg::OP_INS_FIRST)
                        at = 0;
                    else if (r.opcode == ple_pkg::OP_INS_LAST)
                        at = list_mirror.size();
                    else
                        at = r.position - 1;
                    list_mirror.insert(at, r.value);
                    push_outcome(ple_pkg::ST_OK, 0, 0, 1'b1);
                end
            end
            ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST, ple_pkg::OP_DEL_AT:
            begin
                // empty check wins over the position check
                if (list_mirror.size() == 0)
                    push_outcome(ple_pkg::ST_EMPTY, 0, 0, 1'b1);
                else if (r.opcode == ple_pkg::OP_DEL_AT &&
                         (r.position < 1 || r.position > list_mirror.size()))
                    push_outcome(ple_pkg::ST_RANGE, 0, 0, 1'b1);
                else
                begin
                    if (r.opcode == ple_pkg::OP_DEL_FIRST)
                        at = 0;
                    else if (r.opcode == ple_pkg::OP_DEL_LAST)
                        at = list_mirror.size() - 1;
                    else
                        at = r.position - 1;
                    removed = list_mirror[at];
                    list_mirror.delete(at);
                    push_outcome(ple_pkg::ST_OK, removed, 0, 1'b1);
                end
            end
            ple_pkg::OP_READ_ALL:
            begin
                if (list_mirror.size() == 0)
                    push_outcome(ple_pkg::ST_EMPTY, 0, 0, 1'b1);
                else
                begin
                    n = (list_mirror.size() < ple_pkg::READ_LIMIT)
                        ? list_mirror.size() : ple_pkg::READ_LIMIT;
                    for (int i = 0; i < n; i++)
                        push_outcome(ple_pkg::ST_OK, list_mirror[i], 4'(i), (i == n - 1));
                end
            end
            default:
                push_outcome(ple_pkg::ST_OK, 0, 0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building (tracks the planned entry count to steer positions)
    // ------------------------------------------------------------------
    function automatic void add_request(logic [2:0] opcode, logic signed [31:0] value,
                                        logic [4:0] position);
        list_request_t r;
        r.opcode   = opcode;
        r.value    = value;
        r.position = position;
        request_backlog.push_back(r);
        case (opcode)
            ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_LAST, ple_pkg::OP_INS_AT:
                if (planned_count < LIST_CAPACITY &&
                    (opcode != ple_pkg::OP_INS_AT ||
                     (position >= 1 && position <= planned_count + 1)))
                    planned_count++;
            ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_LAST, ple_pkg::OP_DEL_AT:
                if (planned_count > 0 &&
                    (opcode != ple_pkg::OP_DEL_AT ||
                     (position >= 1 && position <= planned_count)))
                    planned_count--;
            default:
            begin
            end
        endcase
    endfunction

    // bias: 0 leans to inserts, 1 to deletes, 2 either
    function automatic void add_random_request(int bias);
        int                 roll;
        int                 grp;
        int                 upper;
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [4:0]         position;
        roll = $urandom_range(0, 99);
        grp  = (bias == 2) ? $urandom_range(0, 1) : bias;
        if (roll < 10)
            opcode = ple_pkg::OP_READ_ALL;
        else if (roll < 14)
            opcode = OP_UNUSED;
        else if (grp == 0)
            opcode = 3'($urandom_range(ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_AT));
        else
            opcode = 3'($urandom_range(ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_AT));

        roll = $urandom_range(0, 99);
        if (roll < 5)
            value = 32'sh7fff_ffff;
        else if (roll < 10)
            value = 32'sh8000_0000;
        else
            value = $urandom;

        // mostly legal positions, now and then anything the field can carry
        upper = (grp == 0) ? planned_count + 1 : planned_count;
        if (upper < 1)
            upper = 1;
        if ($urandom_range(0, 99) < 85)
            position = 5'($urandom_range(1, upper));
        else
            position = 5'($urandom_range(0, 31));
        add_request(opcode, value, position);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!(req_ch.valid && !req_fired))
        begin
            // hold an offered transaction until taken, else offer the next one
            if (request_backlog.size() > 0 &&
                (hold_results || $urandom_range(0, 99) >= sender_idle_pct))
            begin
                req_ch.opcode   <= request_backlog[0].opcode;
                req_ch.value    <= request_backlog[0].value;
                req_ch.position <= request_backlog[0].position;
                req_ch.valid    <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Accept requests on the rising edge and predict their results
    always @(posedge clk)
    begin
        list_request_t taken;
        req_fired = rst_n && req_ch.valid && req_ch.ready;
        if (req_fired)
        begin
            taken.opcode   = req_ch.opcode;
            taken.value    = req_ch.value;
            taken.position = req_ch.position;
            void'(request_backlog.pop_front());
            predict_request(taken);
            accepted_requests++;
            // rotate through the idling phases
            case ((accepted_requests / 40) % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
                default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        rsp_ch.ready <= !hold_results && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d element 'h%0h",
                       rsp_ch.status, rsp_ch.element);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_ch.status));
                check_field("element", want.element, rsp_ch.element);
                check_field("element_index", 32'(want.element_index),
                            32'(rsp_ch.element_index));
                check_field("count_after", 32'(want.count_after), 32'(rsp_ch.count_after));
                check_field("last", 32'(want.last), 32'(rsp_ch.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off so the block backs up and stalls req
    // ------------------------------------------------------------------
    initial
    begin
        hold_results = 1'b0;
        wait (accepted_requests >= 100);
        @(posedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
    end

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int random_total;
        int kind;
        int extra;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = '0;
        req_ch.value       = '0;
        req_ch.position    = '0;
        rsp_ch.ready       = 1'b0;
        planned_count      = 0;
        accepted_requests  = 0;
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        req_fired          = 1'b0;

        // directed: empty list cases, position edges, value extremes
        add_request(OP_UNUSED, 32'sh1234_5678, 5'd0);
        add_request(ple_pkg::OP_READ_ALL, 0, 5'd0);
        add_request(ple_pkg::OP_DEL_FIRST, 0, 5'd1);
        add_request(ple_pkg::OP_DEL_LAST, 0, 5'd1);
        add_request(ple_pkg::OP_DEL_AT, 0, 5'd0);
        add_request(ple_pkg::OP_INS_AT, 32'sd5, 5'd0);
        add_request(ple_pkg::OP_INS_AT, 32'sd5, 5'd2);
        add_request(ple_pkg::OP_INS_FIRST, 32'sh7fff_ffff, 5'd0);
        add_request(ple_pkg::OP_INS_LAST, 32'sh8000_0000, 5'd31);
        add_request(ple_pkg::OP_INS_AT, 32'sh0000_0000, 5'd2);
        add_request(ple_pkg::OP_INS_AT, 32'shffff_ffff, 5'd4);
        add_request(ple_pkg::OP_INS_AT, 32'sh5555_aaaa, 5'd1);
        add_request(ple_pkg::OP_INS_AT, 32'sd7, 5'd31);
        add_request(ple_pkg::OP_READ_ALL, 0, 5'd0);
        add_request(ple_pkg::OP_DEL_AT, 0, 5'd0);
        add_request(ple_pkg::OP_DEL_AT, 0, 5'd6);
        add_request(ple_pkg::OP_DEL_AT, 0, 5'd16);
        add_request(ple_pkg::OP_DEL_AT, 0, 5'd3);
        add_request(ple_pkg::OP_DEL_LAST, 0, 5'd0);
        add_request(ple_pkg::OP_DEL_FIRST, 0, 5'd0);
        add_request(ple_pkg::OP_READ_ALL, 0, 5'd0);
        add_request(OP_UNUSED, 32'sh7fff_ffff, 5'd31);

        // random: fill and drain runs with random content, plus mixed noise
        random_total = 0;
        while (random_total < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 2);
            if (kind == 0)
            begin
                while (planned_count < LIST_CAPACITY)
                begin
                    add_random_request(0);
                    random_total++;
                end
                extra = $urandom_range(1, 3);
                repeat (extra) add_random_request(0);
                random_total += extra;
            end
            else if (kind == 1)
            begin
                while (planned_count > 0)
                begin
                    add_random_request(1);
                    random_total++;
                end
                extra = $urandom_range(1, 2);
                repeat (extra) add_random_request(1);
                random_total += extra;
            end
            else
            begin
                repeat (10) add_random_request(2);
                random_total += 10;
            end
        end

        // reset
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every request to go in and every result to come out
        while (request_backlog.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
